// ----- rtl/rgbhsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types and constants for the 8-bit RGB to 0..240 HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  // one restoring-division lane: partial remainder, dividend bits shifting out
  // at the top of acc while quotient bits shift in at the bottom
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] acc;
    logic [7:0] den;
  } lane_t;

  typedef struct packed {
    lane_t      hue;
    lane_t      sat;
    logic       gray;
    logic [7:0] light;
  } pix_t;

  // quotient bits resolved per pipeline stage, and stage count for 8 bits
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = 8 / DIV_BITS_PER_STAGE;

  localparam logic [7:0] SAT_SCALE = 8'd240;
  localparam logic [8:0] HALF_SUM  = 9'd255;
  localparam logic [8:0] FULL_SUM  = 9'd510;

  // 8/17 ~= 241/512, exact after truncation for sums up to 510
  localparam logic [7:0] L_RECIP = 8'd241;

  localparam logic signed [17:0] HUE_STEP   = 18'sd40;
  localparam logic signed [17:0] HUE_G_BASE = 18'sd80;
  localparam logic signed [17:0] HUE_B_BASE = 18'sd160;
  localparam logic signed [17:0] HUE_WRAP   = 18'sd240;

endpackage

// ----- rtl/rgbhsl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_front
// First pipeline stage: max/min, lightness, and dividends/divisors for the
// hue and saturation divisions.
// ----------------------------------------------------------------------------
module rgbhsl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              valid_out,
  output rgbhsl_pkg::pix_t  pix_out
);

  logic                    rmax;
  logic                    gmax;
  logic [7:0]              mx;
  logic [7:0]              mn;
  logic [7:0]              d;
  logic [8:0]              sum;
  logic [8:0]              den_w;
  logic [7:0]              den;
  logic [15:0]             sat_num;
  logic [16:0]             light_p;
  logic signed [17:0]      rs;
  logic signed [17:0]      gs;
  logic signed [17:0]      bs;
  logic signed [17:0]      ds;
  logic signed [17:0]      num_s;
  logic [15:0]             hue_num;
  logic                    valid_r;
  rgbhsl_pkg::pix_t        pix_r;
  rgbhsl_pkg::pix_t        pix_nxt;

  always_comb begin
    // ties: red wins over green, green over blue
    rmax = (red >= green) && (red >= blue);
    gmax = (green >= blue);
    if (rmax) begin
      mx = red;
    end else if (gmax) begin
      mx = green;
    end else begin
      mx = blue;
    end
    if ((red <= green) && (red <= blue)) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end

    d     = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    den_w = rgbhsl_pkg::FULL_SUM - sum;
    den   = (sum < rgbhsl_pkg::HALF_SUM) ? sum[7:0] : den_w[7:0];

    sat_num = 16'(d) * 16'(rgbhsl_pkg::SAT_SCALE);
    light_p = 17'(sum) * 17'(rgbhsl_pkg::L_RECIP);

    rs = signed'({10'b0, red});
    gs = signed'({10'b0, green});
    bs = signed'({10'b0, blue});
    ds = signed'({10'b0, d});

    if (rmax) begin
      num_s = rgbhsl_pkg::HUE_STEP * (gs - bs);
      if (num_s < 0) begin
        num_s = num_s + rgbhsl_pkg::HUE_WRAP * ds;
      end
    end else if (gmax) begin
      num_s = rgbhsl_pkg::HUE_G_BASE * ds + rgbhsl_pkg::HUE_STEP * (bs - rs);
    end else begin
      num_s = rgbhsl_pkg::HUE_B_BASE * ds + rgbhsl_pkg::HUE_STEP * (rs - gs);
    end
    // non-negative and below 240*d here
    hue_num = num_s[15:0];

    pix_nxt.hue.rem = hue_num[15:8];
    pix_nxt.hue.acc = hue_num[7:0];
    pix_nxt.hue.den = d;
    pix_nxt.sat.rem = sat_num[15:8];
    pix_nxt.sat.acc = sat_num[7:0];
    pix_nxt.sat.den = den;
    pix_nxt.gray    = (d == 8'd0);
    pix_nxt.light   = light_p[16:9];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign valid_out = valid_r;
  assign pix_out   = pix_r;

endmodule

// ----- rtl/rgbhsl_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_div_stage
// One divider pipeline stage: two restoring steps on the hue and the
// saturation lanes, lightness and gray flag carried along.
// ----------------------------------------------------------------------------
module rgbhsl_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  rgbhsl_pkg::pix_t  pix_in,
  output logic              valid_out,
  output rgbhsl_pkg::pix_t  pix_out
);

  function automatic rgbhsl_pkg::lane_t div_step(input rgbhsl_pkg::lane_t l);
    logic [8:0]         t;
    logic [8:0]         diff;
    rgbhsl_pkg::lane_t  o;
    t     = {l.rem, l.acc[7]};
    diff  = t - {1'b0, l.den};
    o.den = l.den;
    if (t >= {1'b0, l.den}) begin
      o.rem = diff[7:0];
      o.acc = {l.acc[6:0], 1'b1};
    end else begin
      o.rem = t[7:0];
      o.acc = {l.acc[6:0], 1'b0};
    end
    return o;
  endfunction

  logic              valid_r;
  rgbhsl_pkg::pix_t  pix_r;
  rgbhsl_pkg::pix_t  pix_nxt;

  always_comb begin
    pix_nxt = pix_in;
    for (int i = 0; i < rgbhsl_pkg::DIV_BITS_PER_STAGE; i++) begin
      pix_nxt.hue = div_step(pix_nxt.hue);
      pix_nxt.sat = div_step(pix_nxt.sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign valid_out = valid_r;
  assign pix_out   = pix_r;

endmodule

// ----- rtl/rgb_to_hsl_240.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_240
// 8-bit RGB pixel to hue / saturation / lightness on a 0..240 scale.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------
//  in      | in_red, in_green, in_blue               | in_valid/in_ready
//  out     | out_hue, out_saturation, out_lightness  | out_valid/out_ready
//
//  one pixel per clock while out_ready does not stall the output; pipeline of a
//  front stage plus four divider stages, each resolving two quotient bits of both divisions
//  the output register is the last divider stage
//  a stall on out_ready freezes the whole pipeline; bubbles move forward
//  synchronous active-low reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module rgb_to_hsl_240 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_lightness
);

  localparam int NS = rgbhsl_pkg::DIV_STAGES;

  logic              en;
  logic              v [NS+1];
  rgbhsl_pkg::pix_t  p [NS+1];

  // pipeline moves unless a finished result waits for transfer
  assign en       = !v[NS] || out_ready;
  assign in_ready = en;

  rgbhsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_valid),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .valid_out (v[0]),
    .pix_out   (p[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_div
    rgbhsl_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (v[k]),
      .pix_in    (p[k]),
      .valid_out (v[k+1]),
      .pix_out   (p[k+1])
    );
  end

  assign out_valid      = v[NS];
  assign out_hue        = p[NS].gray ? 8'd0 : p[NS].hue.acc;
  assign out_saturation = p[NS].gray ? 8'd0 : p[NS].sat.acc;
  assign out_lightness  = p[NS].light;

endmodule
